### rtl/core/sia_pkg.sv
`default_nettype none

package sia_pkg;

  // Bitmap row width and the bit-position width inside one row
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);

  localparam int DEF_NUM_SLOTS = 256;

  localparam int MODE_W  = 3;
  localparam int ID_W    = 8;
  localparam int COUNT_W = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC_NEXT  = 3'd0,
    MODE_ALLOC_GIVEN = 3'd1,
    MODE_FREE        = 3'd2,
    MODE_FREE_ALL    = 3'd3,
    MODE_QUERY       = 3'd4
  } mode_t;

endpackage

`default_nettype wire

### rtl/core/sia_ram.sv
`default_nettype none

module sia_ram #(
  parameter int WIDTH = sia_pkg::WORD_BITS,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/slot_id_allocator_top.sv
// Channel  Direction  Handshake          Word
// in       sink       in_valid/in_stall  mode, slot_id
// out      source     out_valid/out_stall ok, granted_id, live_count, full_res
//
// Free-all, out-of-range ids, unused modes and allocate-next with the hint past the
// last slot finish without a bitmap read; other items read and check one bitmap row,
// then read and check a further row each time the free hint scans upward after an
// allocation at the hint (up to ROWS - 1 further rows, one RAM port).
// in_stall is high from accept until the result is loaded into the output register.
// rst empties every slot (per-row valid bits), sets the hint to one and the count to zero.
// A stalled result holds; the next word may still be taken.
`default_nettype none

module slot_id_allocator_top #(
  parameter int NUM_SLOTS = sia_pkg::DEF_NUM_SLOTS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sia_pkg::MODE_W-1:0]   mode,
  input  wire logic [sia_pkg::ID_W-1:0]     slot_id,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              ok,
  output logic      [sia_pkg::ID_W-1:0]     granted_id,
  output logic      [sia_pkg::COUNT_W-1:0]  live_count,
  output logic                              full_res
);

  localparam int HINT_W = $clog2(NUM_SLOTS + 1);
  localparam int WB     = sia_pkg::WORD_BITS;
  localparam int BIT_W  = sia_pkg::BIT_W;
  localparam int ROWS   = (NUM_SLOTS + WB - 1) / WB;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_SRD  = 5'b01000,
    S_SCHK = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   done_pend, done_pend_next;

  logic [sia_pkg::MODE_W-1:0] op_mode;
  logic [HINT_W-1:0]          op_tgt;
  logic [ROW_W-1:0]           cur_row, cur_row_next;
  logic [BIT_W-1:0]           op_bit;
  logic                       res_ok, res_ok_next;
  logic [sia_pkg::ID_W-1:0]   res_gid, res_gid_next;

  logic [HINT_W-1:0] free_hint, free_hint_next;
  logic [HINT_W-1:0] slot_count, slot_count_next;
  logic [ROWS-1:0]   row_valid, row_valid_next;

  logic          ram_we;
  logic [WB-1:0] ram_wdata, ram_rdata, row_word;

  logic              accept, id_in_range, hint_full, last_row;
  logic [HINT_W-1:0] in_tgt;
  logic [31:0]       tgt32;
  logic              tgt_bit;
  logic [WB-1:0]     srch_word, srch_low, valid_mask, cand;
  logic              srch_found;
  logic [BIT_W-1:0]  srch_pos;
  logic [HINT_W-1:0] srch_id;

  assign in_stall    = (state != S_IDLE) || done_pend;
  assign accept      = in_valid && !in_stall;

  assign id_in_range = 32'(slot_id) < 32'(NUM_SLOTS);
  assign hint_full   = free_hint >= HINT_W'(NUM_SLOTS);
  assign last_row    = cur_row == ROW_W'(ROWS - 1);

  always_comb begin
    if (mode == sia_pkg::MODE_ALLOC_NEXT) begin
      in_tgt = free_hint;
    end else begin
      in_tgt = HINT_W'(slot_id);
    end
  end
  assign tgt32 = 32'(in_tgt);

  // Rows never written read as empty
  assign row_word = row_valid[cur_row] ? ram_rdata : '0;
  assign tgt_bit  = row_word[op_bit];

  // Shared first-free search over one bitmap row
  always_comb begin
    valid_mask = '0;
    srch_low   = '1;
    for (int b = 0; b < WB; b++) begin
      valid_mask[b] = (32'(cur_row) * WB + b) < NUM_SLOTS;
    end
    if (state == S_CHK) begin
      srch_word = row_word | (WB'(1) << op_bit);
      for (int b = 0; b < WB; b++) begin
        srch_low[b] = b > 32'(op_bit);
      end
    end else begin
      srch_word = row_word;
    end
    cand       = ~srch_word & valid_mask & srch_low;
    srch_found = |cand;
    srch_pos   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (cand[b]) begin
        srch_pos = BIT_W'(b);
      end
    end
    srch_id = HINT_W'(32'(cur_row) * WB + 32'(srch_pos));
  end

  always_comb begin
    state_next      = state;
    done_pend_next  = done_pend;
    cur_row_next    = cur_row;
    res_ok_next     = res_ok;
    res_gid_next    = res_gid;
    free_hint_next  = free_hint;
    slot_count_next = slot_count;
    row_valid_next  = row_valid;
    ram_we          = 1'b0;
    ram_wdata       = row_word;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_row_next = ROW_W'(tgt32 >> BIT_W);
          res_ok_next  = 1'b0;
          res_gid_next = '0;
          case (mode)
            sia_pkg::MODE_ALLOC_NEXT: begin
              if (hint_full) begin
                done_pend_next = 1'b1;
              end else begin
                res_gid_next = sia_pkg::ID_W'(free_hint);
                state_next   = S_RD;
              end
            end
            sia_pkg::MODE_ALLOC_GIVEN, sia_pkg::MODE_FREE, sia_pkg::MODE_QUERY: begin
              res_gid_next = slot_id;
              if (id_in_range) begin
                state_next = S_RD;
              end else begin
                done_pend_next = 1'b1;
              end
            end
            sia_pkg::MODE_FREE_ALL: begin
              row_valid_next  = '0;
              slot_count_next = '0;
              free_hint_next  = '0;
              res_ok_next     = 1'b1;
              done_pend_next  = 1'b1;
            end
            default: begin
              done_pend_next = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = S_IDLE;
        case (op_mode)
          sia_pkg::MODE_ALLOC_NEXT, sia_pkg::MODE_ALLOC_GIVEN: begin
            if (tgt_bit) begin
              if (op_mode == sia_pkg::MODE_ALLOC_NEXT) begin
                res_gid_next = '0;
              end
              done_pend_next = 1'b1;
            end else begin
              ram_we                  = 1'b1;
              ram_wdata               = srch_word;
              row_valid_next[cur_row] = 1'b1;
              slot_count_next         = slot_count + HINT_W'(1);
              res_ok_next             = 1'b1;
              if (op_tgt == free_hint) begin
                if (srch_found) begin
                  free_hint_next = srch_id;
                  done_pend_next = 1'b1;
                end else if (last_row) begin
                  free_hint_next = HINT_W'(NUM_SLOTS);
                  done_pend_next = 1'b1;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                  state_next   = S_SRD;
                end
              end else begin
                done_pend_next = 1'b1;
              end
            end
          end
          sia_pkg::MODE_FREE: begin
            if (tgt_bit) begin
              ram_we                  = 1'b1;
              ram_wdata               = row_word & ~(WB'(1) << op_bit);
              row_valid_next[cur_row] = 1'b1;
              slot_count_next         = slot_count - HINT_W'(1);
              res_ok_next             = 1'b1;
              if (op_tgt < free_hint) begin
                free_hint_next = op_tgt;
              end
            end
            done_pend_next = 1'b1;
          end
          default: begin
            res_ok_next    = tgt_bit;
            done_pend_next = 1'b1;
          end
        endcase
      end
      S_SRD: begin
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (srch_found) begin
          free_hint_next = srch_id;
          done_pend_next = 1'b1;
          state_next     = S_IDLE;
        end else if (last_row) begin
          free_hint_next = HINT_W'(NUM_SLOTS);
          done_pend_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cur_row_next = cur_row + ROW_W'(1);
          state_next   = S_SRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Load the finished word once the output register is free
    if (done_pend && (!out_valid || !out_stall)) begin
      done_pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done_pend  <= 1'b0;
      out_valid  <= 1'b0;
      free_hint  <= HINT_W'(1);
      slot_count <= '0;
      row_valid  <= '0;
    end else begin
      state      <= state_next;
      done_pend  <= done_pend_next;
      free_hint  <= free_hint_next;
      slot_count <= slot_count_next;
      row_valid  <= row_valid_next;
      if (done_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row <= cur_row_next;
    res_ok  <= res_ok_next;
    res_gid <= res_gid_next;
    if (accept) begin
      op_mode <= mode;
      op_tgt  <= in_tgt;
      op_bit  <= BIT_W'(tgt32);
    end
    if (done_pend && (!out_valid || !out_stall)) begin
      ok         <= res_ok;
      granted_id <= res_gid;
      live_count <= sia_pkg::COUNT_W'(slot_count);
      full_res   <= hint_full;
    end
  end

  sia_ram #(
    .WIDTH(WB),
    .DEPTH(ROWS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_row),
    .wdata(ram_wdata),
    .raddr(cur_row),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire
